FILE: src/fc64_pkg.sv
package fc64_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned KEY_WORDS     = 4;
    localparam int unsigned MIX_SHL       = 3;
    localparam int unsigned MIX_SHR       = 4;
    localparam int unsigned ODD_SEL_SHIFT = 14;
    localparam logic [WORD_W-1:0] SUBKEY_DELTA = 32'h517C_C1B7;

    // register indexes of the key words on the config port
    localparam logic [1:0] REG_KEY_WORD_0 = 2'd0;
    localparam logic [1:0] REG_KEY_WORD_1 = 2'd1;
    localparam logic [1:0] REG_KEY_WORD_2 = 2'd2;
    localparam logic [1:0] REG_KEY_WORD_3 = 2'd3;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } fc64_op_t;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] fc64_key_t;

    // one block in flight between two cells
    typedef struct packed {
        fc64_op_t          op;
        logic [WORD_W-1:0] l;
        logic [WORD_W-1:0] r;
    } fc64_blk_t;

    // subkey offset D = j * delta, mod 2^32
    function automatic logic [WORD_W-1:0] subkey_delta(input int unsigned j);
        logic [WORD_W-1:0] jw;
        jw = j[WORD_W-1:0];
        return jw * SUBKEY_DELTA;
    endfunction

    // key word select: low bits of D for even j, bits 15:14 for odd j
    function automatic logic [1:0] subkey_sel(input int unsigned j);
        logic [WORD_W-1:0] d;
        d = subkey_delta(j);
        if (j[0] == 1'b0) begin
            return d[1:0];
        end
        return 2'(d >> ODD_SEL_SHIFT);
    endfunction

endpackage

FILE: src/fc64_cell.sv
module fc64_cell
    import fc64_pkg::*;
#(
    parameter int unsigned HALF_IDX = 0,
    parameter int unsigned HALVES   = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  fc64_key_t key,
    input  logic      in_valid,
    output logic      in_ready,
    input  fc64_blk_t in_blk,
    output logic      out_valid,
    input  logic      out_ready,
    output fc64_blk_t out_blk
);

    // fixed round numbers of this cell for each direction
    localparam int unsigned     J_ENC   = HALF_IDX;
    localparam int unsigned     J_DEC   = HALVES - 1 - HALF_IDX;
    localparam logic [WORD_W-1:0] D_ENC = subkey_delta(J_ENC);
    localparam logic [WORD_W-1:0] D_DEC = subkey_delta(J_DEC);
    localparam logic [1:0]      SEL_ENC = subkey_sel(J_ENC);
    localparam logic [1:0]      SEL_DEC = subkey_sel(J_DEC);

    logic              valid_reg;
    fc64_blk_t         blk_reg;
    fc64_blk_t         blk_next;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] subkey;
    logic [WORD_W-1:0] masked;
    logic [WORD_W-1:0] t;

    // take a new item when empty or when the neighbor takes ours
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;

    // one half-round: add on encrypt, subtract on decrypt, then swap
    always_comb begin
        mix    = ((in_blk.r << MIX_SHL) ^ (in_blk.r >> MIX_SHR)) + in_blk.r;
        subkey = (in_blk.op == OP_DECRYPT) ? key[SEL_DEC] + D_DEC
                                           : key[SEL_ENC] + D_ENC;
        masked = mix ^ subkey;
        t      = (in_blk.op == OP_DECRYPT) ? in_blk.l - masked : in_blk.l + masked;
        blk_next.op = in_blk.op;
        blk_next.l  = in_blk.r;
        blk_next.r  = t;
    end

    // occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // block payload
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            blk_reg <= blk_next;
        end
    end

endmodule

FILE: src/feistel_block_cipher_64.sv
// 64-bit Feistel block cipher (XTEA-like round, 128-bit key).
//
// Input stream (s_*): one item per 64-bit block; s_tdata carries the two
// words, s_tuser selects encrypt (0) or decrypt (1). Result stream (m_*):
// one item per input item, in the same order, with the processed block.
// Key words are written through the APB port at byte addresses 0, 4, 8, 12
// and read back there; write them only while no item is in flight.
//
// The block runs through a row of 2*DOUBLE_ROUNDS cells, each doing one
// half-round with its own fixed subkey offset for each direction and
// registering the result. Throughput is one item per cycle while the
// receiver keeps taking results.
//
// Reset clears all key words to zero and empties every cell.
// When the receiver stalls, the last cell holds its item; cells further
// back keep filling until each holds an item, so s_tready drops only once
// the whole row is occupied.
module feistel_block_cipher_64
    import fc64_pkg::*;
#(
    parameter int unsigned DOUBLE_ROUNDS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // apb config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // block_first [31:0], block_second [63:32]
    input  logic        s_tuser,   // operation [0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // result_first [31:0], result_second [63:32]
);

    localparam int unsigned HALVES = 2 * DOUBLE_ROUNDS;

    logic [WORD_W-1:0] key_reg [KEY_WORDS];
    fc64_key_t         key;
    logic [1:0]        reg_idx;
    logic              cfg_write;

    fc64_blk_t blk   [HALVES+1];
    logic      valid [HALVES+1];
    logic      ready [HALVES+1];

    // config port decode
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                key_reg[i] <= '0;
            end
        end else if (cfg_write) begin
            key_reg[reg_idx] <= pwdata;
        end
    end

    // register read back
    always_comb begin
        unique case (reg_idx)
            REG_KEY_WORD_0: prdata = key_reg[0];
            REG_KEY_WORD_1: prdata = key_reg[1];
            REG_KEY_WORD_2: prdata = key_reg[2];
            REG_KEY_WORD_3: prdata = key_reg[3];
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < KEY_WORDS; i++) begin
            key[i] = key_reg[i];
        end
    end

    // input side of the row
    assign valid[0]  = s_tvalid;
    assign s_tready  = ready[0];
    assign blk[0].op = fc64_op_t'(s_tuser);
    assign blk[0].l  = s_tdata[31:0];
    assign blk[0].r  = s_tdata[63:32];

    // row of half-round cells
    for (genvar g = 0; g < HALVES; g++) begin : g_cell
        fc64_cell #(
            .HALF_IDX (g),
            .HALVES   (HALVES)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .key       (key),
            .in_valid  (valid[g]),
            .in_ready  (ready[g]),
            .in_blk    (blk[g]),
            .out_valid (valid[g+1]),
            .out_ready (ready[g+1]),
            .out_blk   (blk[g+1])
        );
    end

    // output side: the last cell is the output register
    assign ready[HALVES] = m_tready;
    assign m_tvalid      = valid[HALVES];
    assign m_tdata       = {blk[HALVES].l, blk[HALVES].r};

endmodule

FILE: src/fc64_checker.sv
module fc64_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        pready,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // config port never waits
    a_pready_high: assert property (@(posedge aclk)
        pready)
        else $error("config port not ready");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // a stalled result keeps its data
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    // a free output lets the whole row move, so the input is ready
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is free");

    // reset empties the row
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item offered right after reset");

endmodule

bind feistel_block_cipher_64 fc64_checker u_fc64_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .pready   (pready),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: bench/tb_feistel_block_cipher_64.sv
`timescale 1ns / 100ps

module tb_feistel_block_cipher_64;
    import fc64_pkg::*;

    localparam int unsigned DOUBLE_ROUNDS = 32;
    localparam int unsigned HALF_ROUNDS   = 2 * DOUBLE_ROUNDS;
    localparam int unsigned RESET_CYCLES  = 5;
    localparam int unsigned IDLE_PCT      = 37;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned RAND_PHASES   = 8;
    localparam int unsigned PHASE_ITEMS   = 200;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    // one block offered on the input stream
    typedef struct {
        fc64_op_t          op;
        logic [WORD_W-1:0] first;
        logic [WORD_W-1:0] second;
    } in_block_t;

    // processed block, first word in the low half as on m_tdata
    typedef struct packed {
        logic [WORD_W-1:0] second;
        logic [WORD_W-1:0] first;
    } out_block_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // block_first [31:0], block_second [63:32]
    logic        s_tuser  = 1'b0; // operation [0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // result_first [31:0], result_second [63:32]

    // key words as the block should hold them
    logic [WORD_W-1:0] key_q [KEY_WORDS];

    in_block_t   in_block_q [$];
    out_block_t  out_block_q [$];

    logic        in_taken      = 1'b0;
    logic        no_idle       = 1'b0;
    logic        hold_trigger  = 1'b0;
    logic        hold_started  = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count   = 0;

    feistel_block_cipher_64 #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #6 aclk = ~aclk;

    // round function: shifted mix of the right half plus itself
    function automatic logic [WORD_W-1:0] round_mix(input logic [WORD_W-1:0] r);
        return ((r << 3) ^ (r >> 4)) + r;
    endfunction

    // subkey of half-round j, taken from the current key copy
    function automatic logic [WORD_W-1:0] round_key(input int unsigned j);
        logic [WORD_W-1:0] d;
        logic [1:0]        sel;
        d   = WORD_W'(j) * SUBKEY_DELTA;
        sel = j[0] ? d[15:14] : d[1:0];
        return key_q[sel] + d;
    endfunction

    // full cipher pass over one block
    function automatic out_block_t cipher_block(input fc64_op_t op,
                                                input logic [WORD_W-1:0] first,
                                                input logic [WORD_W-1:0] second);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] t;
        out_block_t        res;
        a = first;
        b = second;
        if (op == OP_ENCRYPT) begin
            for (int unsigned j = 0; j < HALF_ROUNDS; j++) begin
                t = (round_mix(b) ^ round_key(j)) + a;
                a = b;
                b = t;
            end
        end else begin
            for (int unsigned j = HALF_ROUNDS; j > 0; j--) begin
                t = a - (round_mix(b) ^ round_key(j - 1));
                a = b;
                b = t;
            end
        end
        res.first  = b;
        res.second = a;
        return res;
    endfunction

    // random word, biased toward the edges
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(31);
            3: return ~(32'h1 << $urandom_range(31));
            default: return $urandom();
        endcase
    endfunction

    task automatic push_block(input fc64_op_t op, input logic [WORD_W-1:0] first,
                              input logic [WORD_W-1:0] second);
        in_block_t blk;
        blk.op     = op;
        blk.first  = first;
        blk.second = second;
        in_block_q.push_back(blk);
    endtask

    // encrypt a block, then decrypt what comes out under the same key
    task automatic push_round_trip(input logic [WORD_W-1:0] first,
                                   input logic [WORD_W-1:0] second);
        out_block_t enc;
        enc = cipher_block(OP_ENCRYPT, first, second);
        push_block(OP_ENCRYPT, first, second);
        push_block(OP_DECRYPT, enc.first, enc.second);
    endtask

    // apb write: setup cycle, then access cycle
    task automatic write_key(input logic [1:0] idx, input logic [WORD_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        key_q[idx] = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all_keys(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                                  input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
        write_key(REG_KEY_WORD_0, k0);
        write_key(REG_KEY_WORD_1, k1);
        write_key(REG_KEY_WORD_2, k2);
        write_key(REG_KEY_WORD_3, k3);
    endtask

    // wait until every item went in and every result came back
    task automatic drain();
        do begin
            @(negedge aclk);
            #1;
        end while (in_block_q.size() != 0 || s_tvalid || out_block_q.size() != 0);
    endtask

    // edge blocks for both operations, then two round trips
    task automatic push_directed();
        for (int unsigned o = 0; o < 2; o++) begin
            push_block(fc64_op_t'(o), 32'h0000_0000, 32'h0000_0000);
            push_block(fc64_op_t'(o), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            push_block(fc64_op_t'(o), 32'h0000_0000, 32'hFFFF_FFFF);
            push_block(fc64_op_t'(o), 32'hFFFF_FFFF, 32'h0000_0000);
            push_block(fc64_op_t'(o), 32'h8000_0000, 32'h0000_0001);
            push_block(fc64_op_t'(o), 32'hAAAA_AAAA, 32'h5555_5555);
        end
        push_round_trip(32'h0123_4567, 32'h89AB_CDEF);
        push_round_trip(32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    initial begin : stimulus
        int unsigned n;
        for (int unsigned k = 0; k < KEY_WORDS; k++) begin
            key_q[k] = '0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset key, then all-ones key
        push_directed();
        drain();
        write_all_keys('1, '1, '1, '1);
        push_directed();
        drain();

        // random phases, fresh key each time
        for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
            write_all_keys(pick_word(), pick_word(), pick_word(), pick_word());
            no_idle = (ph == 2) || (ph == 5);
            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(7) == 0) begin
                    push_round_trip(pick_word(), pick_word());
                    n += 2;
                end else begin
                    push_block(fc64_op_t'($urandom_range(1)), pick_word(), pick_word());
                    n += 1;
                end
            end
            // long receiver stall while the sender keeps offering
            if (ph == 5) begin
                hold_trigger = 1'b1;
            end
            drain();
        end
        no_idle = 1'b0;

        repeat (2 * HALF_ROUNDS) @(posedge aclk);
        if (mismatch_count == 0 && out_block_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // input driver
    always @(negedge aclk) begin : block_sender
        in_block_t nxt;
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (in_block_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = in_block_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.second, nxt.first};
                s_tuser  <= nxt.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and one long hold
    always @(negedge aclk) begin : result_receiver
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_trigger && !hold_started) begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // predict each accepted item
    always @(posedge aclk) begin : block_capture
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                out_block_q.push_back(cipher_block(fc64_op_t'(s_tuser),
                                                   s_tdata[31:0], s_tdata[63:32]));
            end
        end
    end

    // compare each result with the oldest prediction
    always @(posedge aclk) begin : result_check
        out_block_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (out_block_q.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, m_tdata);
                mismatch_count <= mismatch_count + 1;
            end else begin
                want = out_block_q.pop_front();
                if (m_tdata[31:0] !== want.first || m_tdata[63:32] !== want.second) begin
                    if (m_tdata[31:0] !== want.first) begin
                        $display("%0t: result_first expected %h actual %h",
                                 $time, want.first, m_tdata[31:0]);
                    end
                    if (m_tdata[63:32] !== want.second) begin
                        $display("%0t: result_second expected %h actual %h",
                                 $time, want.second, m_tdata[63:32]);
                    end
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

FILE: feistel_block_cipher_64.f
src/fc64_pkg.sv
src/fc64_cell.sv
src/feistel_block_cipher_64.sv
src/fc64_checker.sv
bench/tb_feistel_block_cipher_64.sv
